@@ rtl/core/mck_pkg.sv @@
package mck_pkg;

  localparam int CHAR_W  = 8;
  localparam int UNIT_W  = 16;
  localparam int DUR_W   = 18;
  localparam int ELEM_W  = 6;
  localparam int LEN_W   = 3;
  localparam int TABLE_DEPTH = 1 << CHAR_W;
  localparam logic [UNIT_W-1:0] UNIT_RESET = 16'd100;

  // Symbol table entry: element count, elements left-aligned, 1 = dash.
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [ELEM_W-1:0] pat;
  } mck_entry_t;

  localparam int ENTRY_W = $bits(mck_entry_t);

  function automatic mck_entry_t mck_symbol(input logic [CHAR_W-1:0] code);
    mck_entry_t e;
    unique case (code)
      "a": e = '{3'd2, 6'b010000};
      "b": e = '{3'd4, 6'b100000};
      "w": e = '{3'd3, 6'b011000};
      "g": e = '{3'd3, 6'b110000};
      "d": e = '{3'd3, 6'b100000};
      "e": e = '{3'd1, 6'b000000};
      "v": e = '{3'd4, 6'b000100};
      "z": e = '{3'd4, 6'b110000};
      "i": e = '{3'd2, 6'b000000};
      "j": e = '{3'd4, 6'b011100};
      "k": e = '{3'd3, 6'b101000};
      "l": e = '{3'd4, 6'b010000};
      "m": e = '{3'd2, 6'b110000};
      "n": e = '{3'd2, 6'b100000};
      "o": e = '{3'd3, 6'b111000};
      "p": e = '{3'd4, 6'b011000};
      "r": e = '{3'd3, 6'b010000};
      "s": e = '{3'd3, 6'b000000};
      "t": e = '{3'd1, 6'b100000};
      "u": e = '{3'd3, 6'b001000};
      "f": e = '{3'd4, 6'b001000};
      "h": e = '{3'd4, 6'b000000};
      "c": e = '{3'd4, 6'b101000};
      "q": e = '{3'd4, 6'b110100};
      "y": e = '{3'd4, 6'b101100};
      "x": e = '{3'd4, 6'b100100};
      "1": e = '{3'd5, 6'b011110};
      "2": e = '{3'd5, 6'b001110};
      "3": e = '{3'd5, 6'b000110};
      "4": e = '{3'd5, 6'b000010};
      "5": e = '{3'd5, 6'b000000};
      "6": e = '{3'd5, 6'b100000};
      "7": e = '{3'd5, 6'b110000};
      "8": e = '{3'd5, 6'b111000};
      "9": e = '{3'd5, 6'b111100};
      "0": e = '{3'd5, 6'b111110};
      ".": e = '{3'd6, 6'b000000};
      ",": e = '{3'd6, 6'b010101};
      ":": e = '{3'd6, 6'b111000};
      ";": e = '{3'd6, 6'b101010};
      "(": e = '{3'd6, 6'b101101};
      ")": e = '{3'd6, 6'b101101};
      "\"": e = '{3'd6, 6'b010010};
      "-": e = '{3'd6, 6'b100001};
      "/": e = '{3'd5, 6'b100100};
      "?": e = '{3'd6, 6'b001100};
      "!": e = '{3'd6, 6'b110011};
      " ": e = '{3'd5, 6'b100010};
      "@": e = '{3'd6, 6'b011010};
      default: e = '{3'd0, 6'b000000};
    endcase
    return e;
  endfunction

endpackage

@@ rtl/core/morse_character_keyer.sv @@
// Morse character keyer. Each character transfer on the s_ side is looked up
// in a 256-entry symbol RAM and expands into a run of (level, duration) pulses
// on the m_ side: an on pulse of one unit per dot or three units per dash,
// each followed by one unit off; when s_tlast marks the end of a message, a
// further two-unit off pulse follows. m_tlast flags the final pulse of each
// character. Codes not in the table give no element pulses. After reset the
// symbol RAM is loaded from the constant table, during which s_tready stays
// low; cfg writes are taken at any time. Steps per character: the transfer,
// the RAM read, then one pulse per cycle (up to 13 pulses) while the output
// register is free; back-pressure on m_tready holds the pulses back. The
// sequencer walks one element at a time from the entry read out of the RAM.
module morse_character_keyer
  import mck_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // config: unit length in ms
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  // s_tdata: [7:0] char_code; s_tlast = message_end
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  // m_tdata: [0] level, [18:1] duration_ms, [23:19] zero; m_tlast = last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  output logic        m_tlast
);

  localparam logic [1:0] ST_FILL = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]        state;
  logic [CHAR_W-1:0] fill_addr;
  logic [UNIT_W-1:0] unit_ms;

  // current character
  logic              msg_end;
  logic [LEN_W-1:0]  len;
  logic [ELEM_W-1:0] pat;
  logic [LEN_W-1:0]  idx;
  logic              phase;   // 0: element on, 1: trailing gap

  // output register
  logic             level;
  logic [DUR_W-1:0] dur;
  logic             last;

  logic [ENTRY_W-1:0] ram_rdata;
  mck_entry_t         entry;
  mck_entry_t         fill_entry;

  assign fill_entry = mck_symbol(fill_addr);

  mck_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (state == ST_FILL),
    .waddr (fill_addr),
    .wdata (fill_entry),
    .raddr (s_tdata[CHAR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign entry = mck_entry_t'(ram_rdata);

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {5'd0, dur, level};
  assign m_tlast  = last;

  logic             out_free;
  logic             in_elem;
  logic             is_dash;
  logic [1:0]       units;
  logic             p_level;
  logic             p_last;
  logic             p_done;
  logic [DUR_W-1:0] unit_x;

  assign out_free = !m_tvalid || m_tready;
  assign in_elem  = (idx < len);
  assign is_dash  = pat[3'(ELEM_W - 1) - idx];
  assign unit_x   = {2'd0, unit_ms};

  // next pulse from the element pointer
  always_comb begin
    if (in_elem && !phase) begin
      p_level = 1'b1;
      units   = is_dash ? 2'd3 : 2'd1;
      p_last  = 1'b0;
      p_done  = 1'b0;
    end else if (in_elem) begin
      p_level = 1'b0;
      units   = 2'd1;
      p_last  = (idx == len - 3'd1) && !msg_end;
      p_done  = p_last;
    end else begin
      p_level = 1'b0;
      units   = 2'd2;
      p_last  = 1'b1;
      p_done  = 1'b1;
    end
  end

  logic [DUR_W-1:0] p_dur;
  assign p_dur = (units[1] ? {unit_x[DUR_W-2:0], 1'b0} : '0) + (units[0] ? unit_x : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      fill_addr <= '0;
      unit_ms   <= UNIT_RESET;
      m_tvalid  <= 1'b0;
      idx       <= '0;
      phase     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unit_ms <= cfg_wdata;
      end

      // load a new pulse when the register frees up, else drop after transfer
      if (state == ST_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_FILL: begin
          fill_addr <= fill_addr + 1'b1;
          if (fill_addr == CHAR_W'(TABLE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            msg_end <= s_tlast;
            state   <= ST_READ;
          end
        end
        ST_READ: begin
          len   <= entry.len;
          pat   <= entry.pat;
          idx   <= '0;
          phase <= 1'b0;
          // unknown code and no message end: nothing to send
          state <= (entry.len == '0 && !msg_end) ? ST_IDLE : ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            level    <= p_level;
            dur      <= p_dur;
            last     <= p_last;
            if (in_elem && !phase) begin
              phase <= 1'b1;
            end else if (in_elem) begin
              phase <= 1'b0;
              idx   <= idx + 1'b1;
            end
            if (p_done) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // no input taken while the symbol RAM is loading
  a_no_accept_in_fill: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> !s_tready)
    else $error("input accepted during table load");

  // a transfer always goes through the RAM read cycle
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_READ))
    else $error("accept not followed by table read");

  // an on pulse is never the last pulse of a character
  a_on_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> !m_tlast)
    else $error("on pulse flagged last");

  // element pointer stays within the entry
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (idx <= len))
    else $error("element pointer beyond entry length");

endmodule

@@ rtl/core/mck_ram.sv @@
module mck_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ tb/sv/mck_pulse_checker.sv @@
// Watches both streams and the unit register, predicts the pulse run of each
// accepted character and compares every output transfer with it.
module mck_pulse_checker
  import mck_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] char_code
  input  logic        s_tlast,    // message_end
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,    // [0] level, [18:1] duration_ms, [23:19] zero
  input  logic        m_tlast,    // last
  output int          errors,
  output int          pending
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DOT_LEN  = 1;
  localparam int DASH_LEN = 3;
  localparam int GAP_LEN  = 1;
  localparam int END_LEN  = 2;

  typedef struct {
    logic             level;
    logic [DUR_W-1:0] dur;
    logic             last;
  } pulse_t;

  pulse_t            pulse_q[$];
  logic [UNIT_W-1:0] unit_len;

  function automatic string morse_elements(input logic [7:0] code);
    case (code)
      "a": return ".-";      "b": return "-...";    "w": return ".--";
      "g": return "--.";     "d": return "-..";     "e": return ".";
      "v": return "...-";    "z": return "--..";    "i": return "..";
      "j": return ".---";    "k": return "-.-";     "l": return ".-..";
      "m": return "--";      "n": return "-.";      "o": return "---";
      "p": return ".--.";    "r": return ".-.";     "s": return "...";
      "t": return "-";       "u": return "..-";     "f": return "..-.";
      "h": return "....";    "c": return "-.-.";    "q": return "--.-";
      "y": return "-.--";    "x": return "-..-";    "1": return ".----";
      "2": return "..---";   "3": return "...--";   "4": return "....-";
      "5": return ".....";   "6": return "-....";   "7": return "--...";
      "8": return "---..";   "9": return "----.";   "0": return "-----";
      ".": return "......";  ",": return ".-.-.-";  ":": return "---...";
      ";": return "-.-.-.";  "(": return "-.--.-";  ")": return "-.--.-";
      "\"": return ".-..-."; "-": return "-....-";  "/": return "-..-.";
      "?": return "..--..";  "!": return "--..--";  " ": return "-...-";
      "@": return ".--.-.";
      default: return "";
    endcase
  endfunction

  function automatic logic [DUR_W-1:0] scaled(input logic [UNIT_W-1:0] u, input int units);
    logic [31:0] prod;
    prod = u * units;
    return prod[DUR_W-1:0];
  endfunction

  task automatic predict_pulses(input logic [7:0] code, input logic msg_end);
    string  pat;
    int     k;
    int     n0;
    pulse_t p;
    pat = morse_elements(code);
    n0  = pulse_q.size();
    for (k = 0; k < pat.len(); k++) begin
      p = '{1'b1, scaled(unit_len, (pat[k] == "-") ? DASH_LEN : DOT_LEN), 1'b0};
      pulse_q.push_back(p);
      p = '{1'b0, scaled(unit_len, GAP_LEN), 1'b0};
      pulse_q.push_back(p);
    end
    if (msg_end) begin
      p = '{1'b0, scaled(unit_len, END_LEN), 1'b0};
      pulse_q.push_back(p);
    end
    if (pulse_q.size() > n0) pulse_q[pulse_q.size()-1].last = 1'b1;
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin : monitor
    pulse_t want;
    if (rst) begin
      pulse_q.delete();
      unit_len = UNIT_RESET;
      errors   = 0;
    end else begin
      if (cfg_we) unit_len = cfg_wdata;
      if (m_tvalid && m_tready) begin
        if (pulse_q.size() == 0) begin
          report_mismatch($sformatf("pulse level %0b dur %0d with none pending",
                                    m_tdata[0], m_tdata[18:1]));
        end else begin
          want = pulse_q.pop_front();
          if (m_tdata[0] !== want.level)
            report_mismatch($sformatf("level got %0b want %0b", m_tdata[0], want.level));
          if (m_tdata[18:1] !== want.dur)
            report_mismatch($sformatf("duration got %0d want %0d", m_tdata[18:1], want.dur));
          if (m_tlast !== want.last)
            report_mismatch($sformatf("last got %0b want %0b", m_tlast, want.last));
          if (m_tdata[23:19] !== 5'd0)
            report_mismatch($sformatf("pad bits got %0h", m_tdata[23:19]));
        end
      end
      if (s_tvalid && s_tready) predict_pulses(s_tdata, s_tlast);
    end
    pending = pulse_q.size();
  end

endmodule

@@ tb/sv/morse_character_keyer_tb.sv @@
// Stimulus and verdict for the Morse keyer. Checking lives in mck_pulse_checker.
module morse_character_keyer_tb;

  timeunit 1ns;
  timeprecision 1ps;

  // Longest stretch with no transfer on either side: the symbol load after
  // reset, or a sender gap plus a receiver stall, or the idle
  // wait before a unit write. Several times the worst of those.
  localparam int STALL_LIMIT = 5000;
  // Settle time after the last pulse: a character with no pulses can still
  // be in the pipe.
  localparam int SETTLE_CYCLES = 32;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;    // [7:0] char_code
  logic        s_tlast = 1'b0;  // message_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // [0] level, [18:1] duration_ms, [23:19] zero
  logic        m_tlast;         // last

  int errors;
  int pending;

  // No idling at all once set (final phase).
  logic calm = 1'b0;
  // Per-message switch for sender gaps, so some messages go back to back.
  bit   sender_gaps = 1'b1;

  // Every code the table knows; the space is one of them.
  string symbol_set = "abwgdevzijklmnoprstufhcqyx1234567890.,:;()\"-/?! @";

  always #5 clk = ~clk;

  morse_character_keyer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  mck_pulse_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .errors    (errors),
    .pending   (pending)
  );

  // Receiver: stall bursts, now and then a quiet stretch
  // with the ready held high so pulses stream out back to back.
  int hold_left;
  int quiet_left;

  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      hold_left  <= 0;
      quiet_left <= 0;
    end else if (calm) begin
      m_tready <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (quiet_left > 0) begin
      quiet_left <= quiet_left - 1;
      m_tready   <= 1'b1;
    end else begin
      case ($urandom_range(0, 15))
        0, 1: begin
          hold_left <= $urandom_range(0, 9);
          m_tready  <= 1'b0;
        end
        2: begin
          quiet_left <= $urandom_range(20, 80);
          m_tready   <= 1'b1;
        end
        default: m_tready <= 1'b1;
      endcase
    end
  end

  // Watchdog: cycles with no transfer on either stream.
  int idle_cycles;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // One character transfer. Valid stays high into the next character unless
  // a gap is drawn, so back-to-back transfers happen too.
  task automatic send_char(input logic [7:0] code, input logic msg_end);
    int n;
    if (!calm && sender_gaps && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 10);
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= code;
    s_tlast  <= msg_end;
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid, let every expected pulse arrive, then let a trailing
  // no-pulse character clear the pipe before touching the register.
  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_unit(input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random messages: 1..6 characters, mostly known codes, the last one
  // flagged; some noise bytes and stray end flags mid-message.
  task automatic send_messages(input int count);
    int         sent;
    int         len;
    int         k;
    logic [7:0] code;
    logic       msg_end;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, 6);
      sender_gaps = ($urandom_range(0, 3) != 0);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(0, 6) == 0)
          code = 8'($urandom_range(0, 255));
        else
          code = symbol_set[$urandom_range(0, symbol_set.len() - 1)];
        msg_end = (k == len - 1) || ($urandom_range(0, 19) == 0);
        send_char(code, msg_end);
        sent++;
      end
    end
  endtask

  // Directed characters: shortest and longest symbols, all-dot and mixed
  // six-element ones, the space, unknown codes with and without message end
  // (uppercase, all-zero, all-ones, around the 7-bit boundary).
  logic [7:0] dir_code[18] = '{"e", "t", "a", ".", "!", "0", "5", " ", 8'h00,
                               8'hFF, "A", "Z", "(", ")", "\"", "@", 8'h7F, 8'h80};
  logic       dir_end[18]  = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
                               1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  initial begin
    int i;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset unit length.
    for (i = 0; i < 18; i++) send_char(dir_code[i], dir_end[i]);
    drain();

    // Unit extremes, including the zero unit.
    set_unit(16'd1);
    send_messages(25);
    drain();

    set_unit(16'hFFFF);
    send_messages(25);
    drain();

    set_unit(16'd0);
    send_messages(15);
    drain();

    set_unit(16'($urandom_range(1, 65535)));
    send_messages(25);
    drain();

    // Last phase: no idling on either side.
    calm <= 1'b1;
    set_unit(16'($urandom_range(1, 65535)));
    send_messages(40);
    drain();

    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/mck_pkg.sv
rtl/core/mck_ram.sv
rtl/core/morse_character_keyer.sv
tb/sv/mck_pulse_checker.sv
tb/sv/morse_character_keyer_tb.sv
